// ===== sv/hbr_pkg.sv =====
// Package for the half-band polyphase resampler: sizes, shared types,
// the sequencer state type and the Q1.15 rounding/saturation function.
// No dependencies.
package hbr_pkg;

	localparam int NUM_PHASE_TAPS = 16;
	localparam int IDX_W = (NUM_PHASE_TAPS > 1) ? $clog2(NUM_PHASE_TAPS) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_PHASE_TAPS - 1);

	localparam int SAMPLE_W = 16;
	localparam int PROD_W = 2 * SAMPLE_W;
	localparam int ACC_W = 40;
	localparam int SUM_W = ACC_W + 2;
	localparam int FRAC_SHIFT = 15;
	localparam int QUOT_W = SUM_W - FRAC_SHIFT;
	localparam int ROUND_BIAS = 1 << (FRAC_SHIFT - 1);

	localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 16'sh7FFF;
	localparam logic signed [SAMPLE_W-1:0] SAT_MIN = 16'sh8000;

	localparam logic FUNC_TAP = 1'b0;
	localparam logic FUNC_SAMPLE = 1'b1;
	localparam logic MODE_INTERP = 1'b0;
	localparam logic MODE_DECIM = 1'b1;
	localparam logic BANK_ODD = 1'b0;
	localparam logic BANK_EVEN = 1'b1;

	typedef logic signed [ACC_W-1:0] acc_t;
	typedef logic signed [SAMPLE_W-1:0] sample_t;

	// One multiply-accumulate step issued by the sequencer.
	typedef struct packed {
		logic vld;
		logic bank;
		logic [IDX_W-1:0] idx;
	} step_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_EMIT0,
		ST_EMIT1
	} state_t;

	// Q*.30 to Q1.15: add half an LSB, arithmetic shift by 15, saturate.
	function automatic sample_t round_sat(input logic signed [ACC_W:0] v);
		logic signed [SUM_W-1:0] biased;
		logic signed [QUOT_W-1:0] quot;
		sample_t res;
		biased = SUM_W'(v) + SUM_W'(ROUND_BIAS);
		quot = biased[SUM_W-1:FRAC_SHIFT];
		if (!quot[QUOT_W-1] && (|quot[QUOT_W-2:SAMPLE_W-1])) begin
			res = SAT_MAX;
		end else if (quot[QUOT_W-1] && !(&quot[QUOT_W-2:SAMPLE_W-1])) begin
			res = SAT_MIN;
		end else begin
			res = quot[SAMPLE_W-1:0];
		end
		return res;
	endfunction

endpackage

// ===== sv/hbr_if.sv =====
// Valid/ready channel interfaces for the resampler's input items and results.
// Depends on hbr_pkg.
interface hbr_in_if;
	import hbr_pkg::*;
	logic valid;
	logic ready;
	logic func;
	logic [4:0] tap_index;
	logic signed [15:0] tap_value;
	logic signed [15:0] sample;
	modport source (output valid, func, tap_index, tap_value, sample, input ready);
	modport sink (input valid, func, tap_index, tap_value, sample, output ready);
endinterface

interface hbr_out_if;
	import hbr_pkg::*;
	logic valid;
	logic ready;
	logic signed [15:0] sample_out;
	logic last;
	modport source (output valid, sample_out, last, input ready);
	modport sink (input valid, sample_out, last, output ready);
endinterface

// ===== sv/hbr_mac.sv =====
// Shared multiply-accumulate unit and the two transposed-form accumulator banks.
// Depends on hbr_pkg.
module hbr_mac import hbr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input step_t step,
	input sample_t tap,
	input sample_t operand,
	output acc_t odd_head,
	output acc_t even_head
);

	logic signed [PROD_W-1:0] prod_s1;
	step_t step_s1;
	acc_t odd_acc_q [NUM_PHASE_TAPS];
	acc_t even_acc_q [NUM_PHASE_TAPS];
	acc_t upstream;
	acc_t acc_new;

	always_ff @(posedge clk) begin
		prod_s1 <= tap * operand;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_s1 <= '0;
		end else begin
			step_s1 <= step;
		end
	end

	// The next-higher accumulator has not been updated yet, since steps run upward.
	always_comb begin
		if (step_s1.idx == LAST_IDX) begin
			upstream = '0;
		end else if (step_s1.bank == BANK_ODD) begin
			upstream = odd_acc_q[step_s1.idx + 1'b1];
		end else begin
			upstream = even_acc_q[step_s1.idx + 1'b1];
		end
		acc_new = upstream + ACC_W'(prod_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PHASE_TAPS; i++) begin
				odd_acc_q[i] <= '0;
				even_acc_q[i] <= '0;
			end
		end else if (step_s1.vld) begin
			if (step_s1.bank == BANK_ODD) begin
				odd_acc_q[step_s1.idx] <= acc_new;
			end else begin
				even_acc_q[step_s1.idx] <= acc_new;
			end
		end
	end

	assign odd_head = odd_acc_q[0];
	assign even_head = even_acc_q[0];

endmodule

// ===== sv/halfband_polyphase_resampler.sv =====
// Top level of the half-band polyphase resampler by two.
// Depends on hbr_pkg, hbr_in_if, hbr_out_if and hbr_mac.
//
// Resamples a Q1.15 stream by two with a two-phase polyphase FIR in transposed
// form. Taps are loaded one per transfer (func = 0): an even prototype position
// k goes to the odd-phase bank, an odd position to the even-phase bank, whose
// last tap is fixed at zero; positions beyond the filter are dropped. A tap load
// leaves the block idle and ready. A sample (func = 1) in interpolate mode
// (mode = 0) runs through both banks and yields two results, odd phase first.
// In decimate mode (mode = 1) the first sample of a pair runs through the odd
// bank while the held sample runs through the even bank and gives one result,
// their sum; the second sample of a pair is only held. A sample that computes
// holds the input not ready until its last result is loaded into the result
// register, which may wait on the sink: one 16x16 multiplier steps through one
// tap per cycle, odd bank then even bank, with one pipeline stage between
// multiply and accumulate, then a drain state, and each result is loaded in its
// own emit state. Results are rounded half up and saturated; last marks the
// final result of each sample that computes. The result register lets a new
// item start while the last result still waits for its transfer. Write mode
// only while idle.

module halfband_polyphase_resampler import hbr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic mode_we,
	input logic mode_wdata,
	hbr_in_if.sink item,
	hbr_out_if.source result
);

	state_t state_q;
	state_t state_d;

	logic mode_q;
	logic pair_q;
	sample_t held_q;
	sample_t x_q;
	sample_t y_q;
	logic dec_q;
	logic bank_q;
	logic [IDX_W-1:0] idx_q;

	sample_t odd_taps_q [NUM_PHASE_TAPS];
	sample_t even_taps_q [NUM_PHASE_TAPS];

	logic out_valid_q;
	sample_t out_sample_q;
	logic out_last_q;

	logic accept;
	logic start_run;
	logic out_free;
	logic out_load;
	sample_t out_sample_d;
	logic out_last_d;
	logic [3:0] tap_pos;

	step_t step;
	sample_t tap_rd;
	sample_t operand;
	acc_t odd_head;
	acc_t even_head;
	logic signed [ACC_W:0] head_sum;

	assign accept = item.valid && item.ready;
	assign tap_pos = item.tap_index[4:1];
	assign out_free = !out_valid_q || result.ready;

	// A sample starts computing unless it is the held second sample of a pair.
	assign start_run = accept && (item.func == FUNC_SAMPLE) &&
		!((mode_q == MODE_DECIM) && pair_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_INTERP;
		end else if (mode_we) begin
			mode_q <= mode_wdata;
		end
	end

	// Tap stores carry no reset; the last even-phase tap is never written.
	always_ff @(posedge clk) begin
		if (accept && (item.func == FUNC_TAP)) begin
			if (!item.tap_index[0]) begin
				if (int'(tap_pos) < NUM_PHASE_TAPS) begin
					odd_taps_q[IDX_W'(tap_pos)] <= item.tap_value;
				end
			end else begin
				if (int'(tap_pos) + 1 < NUM_PHASE_TAPS) begin
					even_taps_q[IDX_W'(tap_pos)] <= item.tap_value;
				end
			end
		end
	end

	// Pair tracking and the held sample only change in decimate mode.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_q <= 1'b0;
			held_q <= '0;
		end else if (accept && (item.func == FUNC_SAMPLE) && (mode_q == MODE_DECIM)) begin
			if (pair_q) begin
				held_q <= item.sample;
				pair_q <= 1'b0;
			end else begin
				pair_q <= 1'b1;
			end
		end
	end

	// Operands for the run: the odd bank always sees the new sample; the even
	// bank sees it too when interpolating, the held sample when decimating.
	always_ff @(posedge clk) begin
		if (start_run) begin
			x_q <= item.sample;
			y_q <= (mode_q == MODE_DECIM) ? held_q : item.sample;
			dec_q <= mode_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q <= BANK_ODD;
			idx_q <= '0;
		end else if (start_run) begin
			bank_q <= BANK_ODD;
			idx_q <= '0;
		end else if (state_q == ST_RUN) begin
			if (idx_q == LAST_IDX) begin
				idx_q <= '0;
				bank_q <= BANK_EVEN;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign head_sum = (ACC_W + 1)'(odd_head) + (ACC_W + 1)'(even_head);

	always_comb begin
		state_d = state_q;
		item.ready = 1'b0;
		out_load = 1'b0;
		out_sample_d = round_sat((ACC_W + 1)'(odd_head));
		out_last_d = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				item.ready = 1'b1;
				if (start_run) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if ((idx_q == LAST_IDX) && (bank_q == BANK_EVEN)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_EMIT0;
			end
			ST_EMIT0: begin
				if (out_free) begin
					out_load = 1'b1;
					if (dec_q == MODE_DECIM) begin
						out_sample_d = round_sat(head_sum);
						out_last_d = 1'b1;
						state_d = ST_IDLE;
					end else begin
						state_d = ST_EMIT1;
					end
				end
			end
			ST_EMIT1: begin
				out_sample_d = round_sat((ACC_W + 1)'(even_head));
				out_last_d = 1'b1;
				if (out_free) begin
					out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Shared MAC feed: one tap of one bank per cycle.
	always_comb begin
		step.vld = (state_q == ST_RUN);
		step.bank = bank_q;
		step.idx = idx_q;
		if (bank_q == BANK_ODD) begin
			tap_rd = odd_taps_q[idx_q];
			operand = x_q;
		end else begin
			tap_rd = (idx_q == LAST_IDX) ? sample_t'(0) : even_taps_q[idx_q];
			operand = y_q;
		end
	end

	hbr_mac u_mac (
		.clk(clk),
		.arst_n(arst_n),
		.step(step),
		.tap(tap_rd),
		.operand(operand),
		.odd_head(odd_head),
		.even_head(even_head)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_sample_q <= out_sample_d;
			out_last_q <= out_last_d;
		end
	end

	assign result.valid = out_valid_q;
	assign result.sample_out = out_sample_q;
	assign result.last = out_last_q;

endmodule

// ===== sv/hbr_checker.sv =====
// Port-level checks for the half-band polyphase resampler, bound to its top level.
// Depends on halfband_polyphase_resampler and its channel interfaces.
module hbr_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic in_func,
	input logic out_valid,
	input logic out_ready,
	input logic signed [15:0] out_sample,
	input logic out_last
);

	// A result that is not taken stays offered and unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_sample) && $stable(out_last))
		else $error("result changed or dropped while stalled");

	// After a tap load the block is ready again right away.
	a_tap_load_fast: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !in_func |=> in_ready)
		else $error("input not ready after a tap load");

	// The second result of an interpolated sample follows its first at once.
	a_second_follows: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_last |=> out_valid && out_last)
		else $error("second result missing after first");

	// No new item is taken while a sample still owes its final result.
	a_no_accept_midpair: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_last |-> !in_ready)
		else $error("input ready while results still pending");

endmodule

bind halfband_polyphase_resampler hbr_checker u_hbr_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(item.valid),
	.in_ready(item.ready),
	.in_func(item.func),
	.out_valid(result.valid),
	.out_ready(result.ready),
	.out_sample(result.sample_out),
	.out_last(result.last)
);
